// ===== rtl/core/bounded_ordered_array_engine_top_assert.svh =====
// Assertion macros for the bounded ordered array engine.
// Included by the port checker; needs nothing else.
`ifndef BOUNDED_ORDERED_ARRAY_ENGINE_TOP_ASSERT_SVH
`define BOUNDED_ORDERED_ARRAY_ENGINE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BOAE_ASSERT_NOW(label, clk_i, rst_ni, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BOAE_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/boae_pkg.sv =====
// Shared types and constants of the bounded ordered array engine.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package boae_pkg;

  localparam int DEPTH_DEFAULT = 256;

  // Field widths.
  localparam int DATA_W = 32;
  localparam int IDX_W  = 9;
  localparam int POS_W  = 8;
  localparam int CNT_W  = 9;
  localparam int CAP_W  = 9;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - POS_W - CNT_W;

  // Register port.
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;
  localparam int CFG_WORD_LSB = 2;
  localparam logic CFG_SEL_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    K_READ       = 3'd0,
    K_WRITE      = 3'd1,
    K_FIND       = 3'd2,
    K_INSERT     = 3'd3,
    K_APPEND     = 3'd4,
    K_REMOVE_AT  = 3'd5,
    K_REMOVE_VAL = 3'd6,
    K_NOP        = 3'd7
  } kind_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  // Start value of the walk pointer; the held start also sets an upward walk.
  typedef enum logic [2:0] {
    PI_NONE = 3'd0,
    PI_ZERO = 3'd1,
    PI_HELD = 3'd2,
    PI_IDX1 = 3'd3,
    PI_HIT1 = 3'd4
  } ptr_init_t;

  // Source of the anchor position of a shift.
  typedef enum logic [1:0] {
    AL_NONE = 2'd0,
    AL_IDX  = 2'd1,
    AL_HELD = 2'd2,
    AL_HIT  = 2'd3
  } at_load_t;

  // Source of the reported position.
  typedef enum logic [1:0] {
    POS_ZERO = 2'd0,
    POS_HIT  = 2'd1,
    POS_AT   = 2'd2
  } pos_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      rd_idx;
    logic      wr_idx;
    logic      wr_at;
    logic      walk;
    logic      walk_wr;
    ptr_init_t ptr_init;
    at_load_t  at_load;
    logic      held_inc;
    logic      held_dec;
    logic      finish;
    status_t   status;
    logic      use_rd;
    pos_sel_t  pos_sel;
  } dp_cmd_t;

  localparam dp_cmd_t CMD_NOP = '{
    capture:  1'b0,
    rd_idx:   1'b0,
    wr_idx:   1'b0,
    wr_at:    1'b0,
    walk:     1'b0,
    walk_wr:  1'b0,
    ptr_init: PI_NONE,
    at_load:  AL_NONE,
    held_inc: 1'b0,
    held_dec: 1'b0,
    finish:   1'b0,
    status:   ST_OK,
    use_rd:   1'b0,
    pos_sel:  POS_ZERO
  };

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_t kind;
    logic  idx_ge_held;
    logic  idx_gt_held;
    logic  full;
    logic  hit;
    logic  walk_done;
    logic  out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bounded_ordered_array_engine_top.sv =====
// Top level of the bounded ordered array engine: stream ports, register port.
// Depends on boae_pkg, boae_ctrl and boae_dp.
`default_nettype none

// Keeps an ordered list of signed 32-bit entries in a single-port-read,
// single-port-write memory and answers one request at a time with exactly
// one result (status, read value, position, count). The capacity register
// (address 0, reset 256) bounds the list together with DEPTH. A request is
// decoded in the cycle after it is taken. A read then waits for its memory
// read, while a write and every range or full rejection finish in decode.
// Find and remove value read one entry per cycle from position 0 up to the
// match; an absent value is reported once the walk reaches the count. Insert
// and append move every entry from the position up by one, and remove at
// index moves every entry above it down by one, at one entry per cycle
// through the memory read port. Remove value moves the entries above the
// match down in the same way. The next request is taken once the result has
// been handed to the output register, which holds it until out_tready.
module bounded_ordered_array_engine_top #(
  parameter int DEPTH = boae_pkg::DEPTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Request stream.
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // in_tdata: index [8:0], value [40:9], zero [47:41].
  input  wire logic [boae_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: kind [2:0].
  input  wire logic [boae_pkg::KIND_W-1:0]      in_tuser,
  // Result stream.
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // out_tdata: read_value [31:0], position [39:32], count [48:40], zero [55:49].
  output logic [boae_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // out_tuser: status [1:0].
  output logic [boae_pkg::STAT_W-1:0]           out_tuser,
  // Register port.
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [boae_pkg::CFG_AW-1:0]      paddr,
  input  wire logic [boae_pkg::CFG_DW-1:0]      pwdata,
  output logic [boae_pkg::CFG_DW-1:0]           prdata,
  output logic                                  pready
);

  boae_pkg::dp_cmd_t           cmd;
  boae_pkg::dp_stat_t          stat;
  logic                        cap_we;
  logic [boae_pkg::CAP_W-1:0]  cap;
  boae_pkg::status_t           res_status;
  logic [boae_pkg::DATA_W-1:0] res_read_value;
  logic [boae_pkg::POS_W-1:0]  res_position;
  logic [boae_pkg::CNT_W-1:0]  res_count;
  logic                        cap_sel;

  // Register decode: one word, selected by the word-address bit.
  assign pready  = 1'b1;
  assign cap_sel = (paddr[boae_pkg::CFG_WORD_LSB] == boae_pkg::CFG_SEL_CAPACITY);
  assign cap_we  = psel && penable && pwrite && pready && cap_sel;
  assign prdata  = cap_sel ? {{(boae_pkg::CFG_DW - boae_pkg::CAP_W){1'b0}}, cap} : '0;

  boae_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  boae_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kind        (in_tuser),
    .in_index       (in_tdata[boae_pkg::IDX_W-1:0]),
    .in_value       (in_tdata[boae_pkg::IDX_W +: boae_pkg::DATA_W]),
    .cap_we         (cap_we),
    .cap_wdata      (pwdata[boae_pkg::CAP_W-1:0]),
    .cap            (cap),
    .out_tready     (out_tready),
    .out_valid      (out_tvalid),
    .out_status     (res_status),
    .out_read_value (res_read_value),
    .out_position   (res_position),
    .out_count      (res_count)
  );

  // Result packing.
  assign out_tuser = res_status;
  assign out_tdata = {{boae_pkg::OUT_PAD_W{1'b0}}, res_count, res_position, res_read_value};

endmodule

`default_nettype wire

// ===== rtl/core/boae_ctrl.sv =====
// Controller state machine of the bounded ordered array engine.
// Depends on boae_pkg; drives the datapath through dp_cmd_t only.
`default_nettype none

module boae_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire boae_pkg::dp_stat_t stat,
  output boae_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and datapath commands. Any step that delivers a result waits
  // for a free output slot and has no side effect while it waits.
  always_comb begin
    state_nxt = state_r;
    cmd       = boae_pkg::CMD_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end

      S_DECODE: begin
        case (stat.kind)
          boae_pkg::K_READ: begin
            if (stat.idx_ge_held) begin
              if (stat.out_free) begin
                cmd.finish = 1'b1;
                cmd.status = boae_pkg::ST_RANGE;
                state_nxt  = S_IDLE;
              end
            end else begin
              cmd.rd_idx = 1'b1;
              state_nxt  = S_RD_WAIT;
            end
          end

          boae_pkg::K_WRITE: begin
            if (stat.out_free) begin
              cmd.finish = 1'b1;
              state_nxt  = S_IDLE;
              if (stat.idx_ge_held) begin
                cmd.status = boae_pkg::ST_RANGE;
              end else begin
                cmd.wr_idx = 1'b1;
              end
            end
          end

          boae_pkg::K_FIND, boae_pkg::K_REMOVE_VAL: begin
            cmd.ptr_init = boae_pkg::PI_ZERO;
            state_nxt    = S_SCAN;
          end

          boae_pkg::K_INSERT, boae_pkg::K_APPEND: begin
            if (stat.full) begin
              if (stat.out_free) begin
                cmd.finish = 1'b1;
                cmd.status = boae_pkg::ST_FULL;
                state_nxt  = S_IDLE;
              end
            end else if (stat.kind == boae_pkg::K_INSERT && stat.idx_gt_held) begin
              if (stat.out_free) begin
                cmd.finish = 1'b1;
                cmd.status = boae_pkg::ST_RANGE;
                state_nxt  = S_IDLE;
              end
            end else begin
              cmd.at_load  = (stat.kind == boae_pkg::K_INSERT) ? boae_pkg::AL_IDX
                                                                : boae_pkg::AL_HELD;
              cmd.ptr_init = boae_pkg::PI_HELD;
              state_nxt    = S_SHIFT_UP;
            end
          end

          boae_pkg::K_REMOVE_AT: begin
            if (stat.idx_ge_held) begin
              if (stat.out_free) begin
                cmd.finish = 1'b1;
                cmd.status = boae_pkg::ST_RANGE;
                state_nxt  = S_IDLE;
              end
            end else begin
              cmd.at_load  = boae_pkg::AL_IDX;
              cmd.ptr_init = boae_pkg::PI_IDX1;
              state_nxt    = S_SHIFT_DN;
            end
          end

          default: begin
            // The unused kind changes nothing and reports success.
            if (stat.out_free) begin
              cmd.finish = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
        endcase
      end

      S_RD_WAIT: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          cmd.use_rd = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      // Compare one entry per cycle from the bottom of the list.
      S_SCAN: begin
        if (stat.hit) begin
          if (stat.kind == boae_pkg::K_REMOVE_VAL) begin
            cmd.at_load  = boae_pkg::AL_HIT;
            cmd.ptr_init = boae_pkg::PI_HIT1;
            state_nxt    = S_SHIFT_DN;
          end else if (stat.out_free) begin
            cmd.finish  = 1'b1;
            cmd.pos_sel = boae_pkg::POS_HIT;
            state_nxt   = S_IDLE;
          end
        end else if (stat.walk_done) begin
          if (stat.out_free) begin
            cmd.finish = 1'b1;
            cmd.status = boae_pkg::ST_ABSENT;
            state_nxt  = S_IDLE;
          end
        end else begin
          cmd.walk = 1'b1;
        end
      end

      // Move entries up by one from the top, then store the new value.
      S_SHIFT_UP: begin
        if (stat.walk_done) begin
          if (stat.out_free) begin
            cmd.wr_at    = 1'b1;
            cmd.held_inc = 1'b1;
            cmd.finish   = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.walk    = 1'b1;
          cmd.walk_wr = 1'b1;
        end
      end

      // Move entries down by one over the removed position.
      S_SHIFT_DN: begin
        if (stat.walk_done) begin
          if (stat.out_free) begin
            cmd.held_dec = 1'b1;
            cmd.finish   = 1'b1;
            cmd.pos_sel  = (stat.kind == boae_pkg::K_REMOVE_VAL) ? boae_pkg::POS_AT
                                                                 : boae_pkg::POS_ZERO;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.walk    = 1'b1;
          cmd.walk_wr = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/boae_dp.sv =====
// Datapath of the bounded ordered array engine: entry memory, count,
// walk pointers, capacity register and result register. Depends on boae_pkg.
`default_nettype none

module boae_dp #(
  parameter int DEPTH = boae_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire boae_pkg::dp_cmd_t             cmd,
  output boae_pkg::dp_stat_t                 stat,
  input  wire logic [boae_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [boae_pkg::IDX_W-1:0]    in_index,
  input  wire logic [boae_pkg::DATA_W-1:0]   in_value,
  input  wire logic                          cap_we,
  input  wire logic [boae_pkg::CAP_W-1:0]    cap_wdata,
  output logic [boae_pkg::CAP_W-1:0]         cap,
  input  wire logic                          out_tready,
  output logic                               out_valid,
  output boae_pkg::status_t                  out_status,
  output logic [boae_pkg::DATA_W-1:0]        out_read_value,
  output logic [boae_pkg::POS_W-1:0]         out_position,
  output logic [boae_pkg::CNT_W-1:0]         out_count
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = boae_pkg::CNT_W;
  localparam int CNT_MAX = (1 << CW) - 1;
  // Largest count the memory can hold, clipped to the count width.
  localparam logic [CW-1:0] DEPTH_CAP = (DEPTH > CNT_MAX) ? CW'(CNT_MAX) : CW'(DEPTH);

  logic [boae_pkg::DATA_W-1:0] mem [DEPTH];

  boae_pkg::kind_t             kind_r;
  logic [CW-1:0]               idx_r;
  logic [boae_pkg::DATA_W-1:0] val_r;
  logic [CW-1:0]               p_r;
  logic [CW-1:0]               q_r;
  logic [CW-1:0]               at_r;
  logic                        dir_up_r;
  logic                        pend_r;
  logic [boae_pkg::DATA_W-1:0] rdata_r;
  logic [CW-1:0]               held_r;
  logic [CW-1:0]               held_nxt;
  logic [boae_pkg::CAP_W-1:0]  cap_r;
  logic                        out_valid_r;
  boae_pkg::status_t           status_r;
  logic [boae_pkg::DATA_W-1:0] rv_r;
  logic [boae_pkg::POS_W-1:0]  pos_r;
  logic [CW-1:0]               cnt_r;

  logic [CW-1:0]               limit;
  logic                        can_issue;
  logic                        issue;
  logic                        rd_en;
  logic [CW-1:0]               rd_addr;
  logic                        wr_en;
  logic [CW-1:0]               wr_addr;
  logic [boae_pkg::DATA_W-1:0] wr_data;
  logic                        out_free;

  // The limit is the smaller of the capacity and the built depth.
  assign limit = (cap_r < DEPTH_CAP) ? cap_r : DEPTH_CAP;

  // A walk reads one entry per cycle until it reaches its bound.
  assign can_issue = dir_up_r ? (p_r > at_r) : (p_r < held_r);
  assign issue     = cmd.walk && can_issue;
  assign rd_en     = cmd.rd_idx || issue;
  assign rd_addr   = cmd.rd_idx ? idx_r : (dir_up_r ? p_r - 1'b1 : p_r);

  // Single write port: shift write-back, plain write or insert/append store.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = val_r;
    if (cmd.walk && cmd.walk_wr && pend_r) begin
      wr_en   = 1'b1;
      wr_addr = dir_up_r ? q_r + 1'b1 : q_r - 1'b1;
      wr_data = rdata_r;
    end else if (cmd.wr_idx) begin
      wr_en = 1'b1;
    end else if (cmd.wr_at) begin
      wr_en   = 1'b1;
      wr_addr = at_r;
    end
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    held_nxt = held_r;
    if (cmd.held_inc) begin
      held_nxt = held_r + 1'b1;
    end else if (cmd.held_dec) begin
      held_nxt = held_r - 1'b1;
    end
  end

  // Status toward the controller.
  assign stat.kind        = kind_r;
  assign stat.idx_ge_held = (idx_r >= held_r);
  assign stat.idx_gt_held = (idx_r > held_r);
  assign stat.full        = (held_r >= limit);
  assign stat.hit         = pend_r && (rdata_r == val_r);
  assign stat.walk_done   = !pend_r && !can_issue;
  assign stat.out_free    = out_free;

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(wr_addr)] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[AW'(rd_addr)];
    end
  end

  // Request capture and walk pointers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= boae_pkg::kind_t'(in_kind);
      idx_r  <= in_index;
      val_r  <= in_value;
    end
    case (cmd.ptr_init)
      boae_pkg::PI_ZERO: begin
        p_r      <= '0;
        dir_up_r <= 1'b0;
      end
      boae_pkg::PI_HELD: begin
        p_r      <= held_r;
        dir_up_r <= 1'b1;
      end
      boae_pkg::PI_IDX1: begin
        p_r      <= idx_r + 1'b1;
        dir_up_r <= 1'b0;
      end
      boae_pkg::PI_HIT1: begin
        p_r      <= q_r + 1'b1;
        dir_up_r <= 1'b0;
      end
      default: begin
        if (issue) begin
          p_r <= dir_up_r ? p_r - 1'b1 : p_r + 1'b1;
        end
      end
    endcase
    if (issue) begin
      q_r <= rd_addr;
    end
    case (cmd.at_load)
      boae_pkg::AL_IDX:  at_r <= idx_r;
      boae_pkg::AL_HELD: at_r <= held_r;
      boae_pkg::AL_HIT:  at_r <= q_r;
      default:           at_r <= at_r;
    endcase
  end

  // Control registers: read in flight, count, capacity, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      held_r      <= '0;
      cap_r       <= boae_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture || cmd.ptr_init != boae_pkg::PI_NONE) begin
        pend_r <= 1'b0;
      end else if (cmd.walk) begin
        pend_r <= can_issue;
      end
      held_r <= held_nxt;
      if (cap_we) begin
        cap_r <= cap_wdata;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status_r <= cmd.status;
      rv_r     <= cmd.use_rd ? rdata_r : '0;
      cnt_r    <= held_nxt;
      case (cmd.pos_sel)
        boae_pkg::POS_HIT: pos_r <= q_r[boae_pkg::POS_W-1:0];
        boae_pkg::POS_AT:  pos_r <= at_r[boae_pkg::POS_W-1:0];
        default:           pos_r <= '0;
      endcase
    end
  end

  assign cap            = cap_r;
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_read_value = rv_r;
  assign out_position   = pos_r;
  assign out_count      = cnt_r;

endmodule

`default_nettype wire

// ===== rtl/core/boae_checker.sv =====
// Port-level checker of the bounded ordered array engine, bound to the top.
// Depends on boae_pkg and bounded_ordered_array_engine_top_assert.svh.
`default_nettype none

`include "bounded_ordered_array_engine_top_assert.svh"

module boae_checker #(
  parameter int DEPTH = boae_pkg::DEPTH_DEFAULT
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [boae_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [boae_pkg::STAT_W-1:0]     out_tuser
);

  localparam int CW      = boae_pkg::CNT_W;
  localparam int CNT_MAX = (1 << CW) - 1;
  localparam logic [CW-1:0] COUNT_TOP = (DEPTH > CNT_MAX) ? CW'(CNT_MAX) : CW'(DEPTH);
  localparam int POS_LSB = boae_pkg::DATA_W;
  localparam int CNT_LSB = boae_pkg::DATA_W + boae_pkg::POS_W;

  logic                           in_take;
  logic                           failed;
  logic [boae_pkg::DATA_W-1:0]    rd_val;
  logic [boae_pkg::POS_W-1:0]     pos_val;
  logic [CW-1:0]                  cnt_val;

  assign in_take = in_tvalid && in_tready;
  assign failed  = (out_tuser != boae_pkg::ST_OK);
  assign rd_val  = out_tdata[boae_pkg::DATA_W-1:0];
  assign pos_val = out_tdata[POS_LSB +: boae_pkg::POS_W];
  assign cnt_val = out_tdata[CNT_LSB +: CW];

  // A stalled result keeps its payload.
  `BOAE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // The block is busy in the cycle after it takes a request.
  `BOAE_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_take, !in_tready, "request taken while still decoding the previous one")

  // The reported count never exceeds what the memory holds.
  `BOAE_ASSERT_NOW(a_count_bound, clk, rst_n, out_tvalid, cnt_val <= COUNT_TOP, "count above the built depth")

  // A failed request reports neither data nor a position.
  `BOAE_ASSERT_NOW(a_fail_clean, clk, rst_n, out_tvalid && failed, rd_val == '0 && pos_val == '0, "failed request carries data")

endmodule

bind bounded_ordered_array_engine_top boae_checker #(
  .DEPTH (DEPTH)
) u_boae_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
